[design/assert_macros.svh]
// assertion macros used by the top-level design file
// no dependencies; define ASSERT_OFF to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define CPQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define CPQ_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CPQ_ASSERT(lbl, clk, rstn, prop)
`define CPQ_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[design/cpq_pkg.sv]
// types and constants of the calibrated pitch quantizer
// no dependencies
package cpq_pkg;

  localparam int NumChannelsDef = 4;
  localparam int QueueDepth     = 2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_C2C   = 2'd1,
    OP_C2D   = 2'd2,
    OP_QUANT = 2'd3
  } cpq_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SPAN = 2'd1,
    ST_SAT       = 2'd2,
    ST_RSVD      = 2'd3
  } cpq_status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_GO1, S_WAIT1, S_QNT, S_RND, S_MUL2, S_RCP2, S_SAT2, S_OUT
  } cpq_state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         channel;
    logic signed [15:0] value;
    logic signed [7:0]  step;
    logic [11:0]        point_low;
    logic [11:0]        point_mid;
    logic [11:0]        point_high;
  } cpq_in_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic [1:0]         status;
  } cpq_out_t;

  // work handed from front to back
  typedef struct packed {
    logic               direct;
    cpq_op_e            op;
    logic signed [15:0] value;
    logic signed [7:0]  step;
    logic signed [12:0] span;
    logic [11:0]        offset;
    cpq_status_e        status;
  } cpq_job_t;

endpackage

[design/cpq_front.sv]
// front end: accepts items, holds per-channel calibration, classifies work
// depends on cpq_pkg
module cpq_front import cpq_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cpq_in_t  in_data_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cpq_job_t q_job_o
);

  logic signed [12:0] span_q [NUM_CHANNELS];
  logic [11:0]        off_q  [NUM_CHANNELS];
  logic signed [12:0] span_rd;
  logic [11:0]        off_rd;
  logic               present;
  logic               accept;
  logic signed [12:0] new_span;

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;
  assign present  = 32'(in_data_i.channel) < NUM_CHANNELS;
  assign new_span = $signed({1'b0, in_data_i.point_high}) -
                    $signed({1'b0, in_data_i.point_low});

  // calibration read, absent channel reads zero
  always_comb begin
    span_rd = '0;
    off_rd  = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (32'(in_data_i.channel) == i) begin
        span_rd = span_q[i];
        off_rd  = off_q[i];
      end
    end
  end

  // calibration store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        span_q[i] <= '0;
        off_q[i]  <= '0;
      end
    end else if (accept && cpq_op_e'(in_data_i.op) == OP_LOAD) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (32'(in_data_i.channel) == i) begin
          span_q[i] <= new_span;
          off_q[i]  <= in_data_i.point_mid;
        end
      end
    end
  end

  // classify: loads and zero spans finish without arithmetic
  always_comb begin
    q_job_o.op     = cpq_op_e'(in_data_i.op);
    q_job_o.value  = in_data_i.value;
    q_job_o.step   = in_data_i.step;
    q_job_o.span   = span_rd;
    q_job_o.offset = off_rd;
    q_job_o.direct = 1'b0;
    q_job_o.status = ST_OK;
    if (cpq_op_e'(in_data_i.op) == OP_LOAD) begin
      q_job_o.direct = 1'b1;
      if (present && new_span == '0) q_job_o.status = ST_ZERO_SPAN;
    end else if (span_rd == '0) begin
      q_job_o.direct = 1'b1;
      q_job_o.status = ST_ZERO_SPAN;
    end
  end

endmodule

[design/cpq_queue.sv]
// short job queue between front and back
// depends on cpq_pkg
module cpq_queue import cpq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cpq_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output cpq_job_t job_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cpq_job_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];

  // pointer and fill update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (32'(wr_q) == QueueDepth - 1) ? '0 : wr_q + 1'b1;
    if (pop_i)  rd_d = (32'(rd_q) == QueueDepth - 1) ? '0 : rd_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

[design/cpq_div.sv]
// serial signed divider, one quotient bit per cycle, truncates toward zero
// depends on cpq_pkg
module cpq_div import cpq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] dividend_i,
  input  logic signed [15:0] divisor_i,
  output logic               done_o,
  output logic signed [31:0] quotient_o
);

  logic        run_q;
  logic [5:0]  cnt_q;
  logic [31:0] quo_q;
  logic [15:0] rem_q, dsr_q;
  logic        neg_q;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;

  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign done_o  = run_q && cnt_q == 6'd32;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (done_o) begin
      run_q <= 1'b0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // restoring step on magnitudes
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[31] ? 32'(-dividend_i) : 32'(dividend_i);
      dsr_q <= divisor_i[15] ? 16'(-divisor_i) : 16'(divisor_i);
      rem_q <= '0;
      neg_q <= dividend_i[31] ^ divisor_i[15];
    end else if (run_q && !done_o) begin
      if (!rem_sub[16]) begin
        rem_q <= rem_sub[15:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[15:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

[design/cpq_back.sv]
// back end: conversion sequencer around the shared divider, result register
// depends on cpq_pkg, cpq_div
module cpq_back import cpq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  cpq_job_t q_job_i,
  output logic     q_pop_o,
  input  logic     pop_i,
  output logic     empty_o,
  output cpq_out_t out_data_o
);

  localparam logic signed [15:0] KNeg24k   = -16'sd24000;
  localparam logic [14:0]        K24k      = 15'd24000;
  localparam logic [12:0]        KRecip    = 13'd5243;
  // ceil(2^30 / 375), exact for dividends below 2^21
  localparam logic [21:0]        KRecip375 = 22'd2863312;
  localparam logic signed [31:0] KNumLo    = -32'sd24000;
  // 4096 * 24000, first numerator past the code range
  localparam logic signed [31:0] KNumHi    = 32'sd98304000;

  cpq_state_e         state_q, state_d;
  cpq_job_t           job_q;
  logic signed [31:0] num_q;
  logic signed [15:0] den_q;
  logic signed [15:0] cents_q, res_q;
  logic [29:0]        prod_q;
  logic [42:0]        prod2_q;
  logic               neg_q, sat_q;
  logic               out_valid_q, out_valid_d;
  cpq_out_t           out_q;
  logic               out_load;
  logic               div_start, div_done;
  logic signed [31:0] div_quo;

  logic signed [17:0] diff;
  logic signed [33:0] p1;
  logic signed [16:0] t;
  logic [16:0]        tmag;
  logic [10:0]        qm;
  logic signed [10:0] qs, q2;
  logic signed [18:0] c100;
  logic signed [28:0] p2;
  logic [26:0]        p3;

  cpq_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(num_q),
    .divisor_i (den_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign q_pop_o    = state_q == S_IDLE && !q_empty_i;
  assign div_start  = state_q == S_GO1;
  assign out_load   = state_q == S_OUT && (!out_valid_q || pop_i);
  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

  // arithmetic of each step
  assign diff = $signed({{2{job_q.value[15]}}, job_q.value}) - $signed({6'b0, job_q.offset});
  assign p1   = diff * KNeg24k;
  assign t    = cents_q[15] ? $signed({cents_q[15], cents_q}) - 17'sd50
                            : $signed({cents_q[15], cents_q}) + 17'sd50;
  assign tmag = t[16] ? 17'(-t) : 17'(t);
  assign qm   = prod_q[29:19];
  assign qs   = neg_q ? -$signed(qm) : $signed(qm);
  assign q2   = qs + 11'($signed(job_q.step));
  assign c100 = q2 * $signed(8'sd100);
  assign p2   = cents_q * job_q.span;
  assign p3   = job_q.offset * K24k;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          if (q_job_i.direct) state_d = S_OUT;
          else if (q_job_i.op == OP_C2D) state_d = S_MUL2;
          else state_d = S_MUL1;
        end
      end
      S_MUL1:  state_d = S_GO1;
      S_GO1:   state_d = S_WAIT1;
      S_WAIT1: if (div_done) state_d = (job_q.op == OP_C2C) ? S_OUT : S_QNT;
      S_QNT:   state_d = S_RND;
      S_RND:   state_d = S_MUL2;
      S_MUL2:  state_d = S_RCP2;
      S_RCP2:  state_d = S_SAT2;
      S_SAT2:  state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        job_q   <= q_job_i;
        cents_q <= q_job_i.value;
        res_q   <= '0;
        sat_q   <= 1'b0;
      end
      S_MUL1: begin
        num_q <= p1[31:0] + 32'(job_q.span);
        den_q <= {{2{job_q.span[12]}}, job_q.span, 1'b0};
      end
      S_WAIT1: begin
        if (div_done) begin
          if (div_quo > 32'sd32767) begin
            cents_q <= 16'sd32767;
            sat_q   <= 1'b1;
          end else if (div_quo < -32'sd32768) begin
            cents_q <= -16'sd32768;
            sat_q   <= 1'b1;
          end else begin
            cents_q <= div_quo[15:0];
          end
          res_q <= (div_quo > 32'sd32767) ? 16'sd32767 :
                   (div_quo < -32'sd32768) ? -16'sd32768 : div_quo[15:0];
        end
      end
      S_QNT: begin
        prod_q <= tmag * KRecip;
        neg_q  <= t[16];
      end
      S_RND: begin
        if (c100 > 19'sd32767) begin
          cents_q <= 16'sd32767;
          sat_q   <= 1'b1;
        end else if (c100 < -19'sd32768) begin
          cents_q <= -16'sd32768;
          sat_q   <= 1'b1;
        end else begin
          cents_q <= c100[15:0];
        end
      end
      S_MUL2: begin
        num_q <= -(32'(p2) <<< 1) + $signed({5'b0, p3}) + 32'sd12000;
      end
      // divide by 24000 as a shift by 6 and a reciprocal multiply by 1/375
      S_RCP2: begin
        prod2_q <= num_q[26:6] * KRecip375;
      end
      // clamp to the code range, small negatives truncate to zero
      S_SAT2: begin
        if (num_q <= KNumLo) begin
          res_q <= '0;
          sat_q <= 1'b1;
        end else if (num_q < 32'sd0) begin
          res_q <= '0;
        end else if (num_q >= KNumHi) begin
          res_q <= 16'sd4095;
          sat_q <= 1'b1;
        end else begin
          res_q <= {4'b0, prod2_q[41:30]};
        end
      end
      default: ;
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (pop_i && out_valid_q) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.result <= res_q;
      out_q.status <= job_q.direct ? job_q.status : (sat_q ? ST_SAT : ST_OK);
    end
  end

endmodule

[design/calibrated_pitch_quantizer_core.sv]
// calibrated pitch quantizer, top level
// depends on cpq_pkg, cpq_front, cpq_queue, cpq_back, assert_macros.svh
//
// Items enter on a queue-style port: in_data_i is taken at an edge with push high and
// full low. Results leave the same way: out_data_o holds the oldest result while
// empty is low and is taken at an edge with pop high.
// The front end reads or loads the per-channel calibration as an item is taken and
// places a job in a two-entry queue; the back end runs the arithmetic.
// Loads and zero-span items go to the result register without arithmetic. Code to
// cents divides by twice the channel span in a pass through the serial divider; the
// division by 24000 is a shift and a reciprocal multiply.
// Items are worked one at a time in the back end, which takes no new item until
// the last has been loaded into the result register; up to two further items wait
// in the queue, so push may be taken while a result waits.
// Reset clears the calibration store (span zero on all channels) and the queue, and
// empties the result register. When pop stays low, the result is held, the back end
// waits, and full rises once the queue fills.
`include "assert_macros.svh"
module calibrated_pitch_quantizer_core import cpq_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  cpq_in_t  in_data_i,
  input  logic     pop,
  output logic     empty,
  output cpq_out_t out_data_o
);

  logic     q_push, q_full, q_pop, q_empty;
  cpq_job_t q_wr_job, q_rd_job;

  assign full = q_full;

  cpq_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .in_data_i(in_data_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (q_wr_job)
  );

  cpq_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_wr_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .job_o  (q_rd_job)
  );

  cpq_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_job_i   (q_rd_job),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_data_o(out_data_o)
  );

  // internal checks
  `CPQ_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, q_push && q_full && !q_pop)
  `CPQ_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, q_pop && q_empty)
  `CPQ_ASSERT_NEVER(a_status_code, clk_i, rst_ni, !empty && out_data_o.status == ST_RSVD)

endmodule

[dv/calibrated_pitch_quantizer_core_test.sv]
// testbench for calibrated_pitch_quantizer_core: directed and random beats checked
// against an in-bench integer predictor of the per-channel calibration arithmetic
// depends on cpq_pkg and the design files
module calibrated_pitch_quantizer_core_test import cpq_pkg::*;;

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  logic     full;
  cpq_in_t  in_data_i;
  logic     pop;
  logic     empty;
  cpq_out_t out_data_o;

  calibrated_pitch_quantizer_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .pop        (pop),
    .empty      (empty),
    .out_data_o (out_data_o)
  );

  // predictor copy of the calibration store
  logic signed [12:0] span_q [NumChannelsDef];
  logic [11:0]        offset_q [NumChannelsDef];
  cpq_out_t           pending_results [$];
  int                 mismatch_cnt;
  bit                 rx_stall_en;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("calibrated_pitch_quantizer_core_test NOT OK");
    $finish;
  end

  function automatic longint trunc_div(longint num, longint den);
    // sv division truncates toward zero like c
    return num / den;
  endfunction

  function automatic longint sat_to(longint v, longint lo, longint hi, ref bit sat);
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic longint code_to_cents(longint code, longint sp, longint off,
                                           ref bit sat);
    return sat_to(trunc_div(-24000 * (code - off) + sp, 2 * sp), -32768, 32767, sat);
  endfunction

  function automatic longint cents_to_code(longint cents, longint sp, longint off,
                                           ref bit sat);
    return sat_to(trunc_div(-2 * cents * sp + 24000 * off + 12000, 24000), 0, 4095, sat);
  endfunction

  // expected result of one beat, updating the calibration copy
  function automatic cpq_out_t quantize_predict(cpq_in_t it);
    cpq_out_t    r;
    longint      sp;
    longint      off;
    longint      res;
    longint      cents;
    longint      q;
    bit          sat;
    cpq_status_e st;
    sp = span_q[it.channel];
    off = offset_q[it.channel];
    res = 0;
    sat = 1'b0;
    st = ST_OK;
    if (cpq_op_e'(it.op) == OP_LOAD) begin
      span_q[it.channel] = 13'(longint'(it.point_high) - longint'(it.point_low));
      offset_q[it.channel] = it.point_mid;
      if (it.point_high == it.point_low) st = ST_ZERO_SPAN;
    end else if (sp == 0) begin
      st = ST_ZERO_SPAN;
    end else if (cpq_op_e'(it.op) == OP_C2C) begin
      res = code_to_cents(it.value, sp, off, sat);
    end else if (cpq_op_e'(it.op) == OP_C2D) begin
      res = cents_to_code(it.value, sp, off, sat);
    end else begin
      cents = code_to_cents(it.value, sp, off, sat);
      q = trunc_div(cents + (cents < 0 ? -50 : 50), 100) + it.step;
      cents = sat_to(q * 100, -32768, 32767, sat);
      res = cents_to_code(cents, sp, off, sat);
    end
    if (st == ST_OK && sat) st = ST_SAT;
    r.result = 16'(res);
    r.status = st;
    return r;
  endfunction

  // send one beat, after a random gap when gaps is set; push stays high for back to back beats
  task automatic send_beat(cpq_in_t it, bit gaps = 1'b1);
    int gap;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16)) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_results.push_back(quantize_predict(it));
  endtask

  function automatic cpq_in_t make_beat(cpq_op_e op, int ch, int val, int stp = 0,
                                        int lo = 0, int mid = 0, int hi = 0);
    cpq_in_t it;
    it.op = op;
    it.channel = 2'(ch);
    it.value = 16'(val);
    it.step = 8'(stp);
    it.point_low = 12'(lo);
    it.point_mid = 12'(mid);
    it.point_high = 12'(hi);
    return it;
  endfunction

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // result checker, pop stalls drawn per beat while rx_stall_en is set
  initial begin
    int       stall;
    cpq_out_t exp_beat;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_stall_en ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16)) : 0;
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %0d", out_data_o.result);
      end else begin
        exp_beat = pending_results.pop_front();
        if (out_data_o.result !== exp_beat.result || out_data_o.status !== exp_beat.status)
        begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected %0d/%0d got %0d/%0d", exp_beat.result,
                     exp_beat.status, out_data_o.result, out_data_o.status);
        end
      end
    end
  end

  // zero span after reset, extremes, every op and the special cases
  task automatic test_directed();
    send_beat(make_beat(OP_C2C, 0, 100));
    send_beat(make_beat(OP_C2D, 3, -32768));
    send_beat(make_beat(OP_QUANT, 2, 4095, 127));
    send_beat(make_beat(OP_LOAD, 1, 0, 0, 500, 500, 500));
    send_beat(make_beat(OP_C2C, 1, 600));
    send_beat(make_beat(OP_LOAD, 0, 0, 0, 4095, 2048, 0));
    send_beat(make_beat(OP_LOAD, 1, 0, 0, 0, 4095, 4095));
    send_beat(make_beat(OP_LOAD, 2, 0, 0, 100, 0, 4095));
    send_beat(make_beat(OP_LOAD, 3, 0, 0, 2000, 2047, 2001));
    send_beat(make_beat(OP_C2C, 0, 0));
    send_beat(make_beat(OP_C2C, 0, 4095));
    send_beat(make_beat(OP_C2C, 3, 32767));
    send_beat(make_beat(OP_C2C, 3, -32768));
    send_beat(make_beat(OP_C2D, 0, 32767));
    send_beat(make_beat(OP_C2D, 0, -32768));
    send_beat(make_beat(OP_C2D, 1, 0));
    send_beat(make_beat(OP_QUANT, 0, 2048, -128));
    send_beat(make_beat(OP_QUANT, 0, 2048, 127));
    send_beat(make_beat(OP_QUANT, 3, -32768, -1));
    send_beat(make_beat(OP_QUANT, 3, 32767, 127));
    send_beat(make_beat(OP_QUANT, 2, 1000, 0));
    send_beat(make_beat(OP_QUANT, 1, 30, -5));
  endtask

  // hold the sender off until every result has come, send three beats, the last two without gaps, and drain again
  task automatic test_drain_pause();
    wait_drained();
    send_beat(make_beat(OP_C2C, 0, 1234));
    send_beat(make_beat(OP_QUANT, 0, 1234, 3), 1'b0);
    send_beat(make_beat(OP_C2D, 0, 1200), 1'b0);
    wait_drained();
  endtask

  // random beats: mostly sane calibrations and codes, some wild values
  task automatic test_random(int n, bit stalls);
    cpq_in_t it;
    int      lo;
    rx_stall_en = stalls;
    for (int i = 0; i < n; i++) begin
      it = cpq_in_t'({$urandom, $urandom});
      if ($urandom_range(0, 9) == 0) begin
        it.op = OP_LOAD;
        if ($urandom_range(0, 4) != 0) begin
          lo = $urandom_range(0, 1000);
          it.point_low = 12'(4095 - lo);
          it.point_high = 12'($urandom_range(0, 1000));
          it.point_mid = 12'($urandom_range(1500, 2600));
        end
      end else if ($urandom_range(0, 3) != 0) begin
        if (cpq_op_e'(it.op) == OP_LOAD) it.op = OP_QUANT;
        if (cpq_op_e'(it.op) == OP_C2D) it.value = 16'($signed($urandom_range(0, 12000)) - 6000);
        else it.value = 16'($urandom_range(0, 4095));
        if ($urandom_range(0, 1)) it.step = 8'($signed($urandom_range(0, 48)) - 24);
      end
      send_beat(it, stalls);
    end
  endtask

  initial begin
    int tail;
    rst_ni = 1'b0;
    push = 1'b0;
    in_data_i = '0;
    mismatch_cnt = 0;
    rx_stall_en = 1'b1;
    for (int c = 0; c < NumChannelsDef; c++) begin
      span_q[c] = '0;
      offset_q[c] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random(550, 1'b1);
    test_random(100, 1'b0);
    test_random(480, 1'b1);
    push <= 1'b0;
    tail = 0;
    while (pending_results.size() != 0 && tail < 200000) begin
      @(posedge clk_i);
      tail++;
    end
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0)
      $display("calibrated_pitch_quantizer_core_test OK");
    else
      $display("calibrated_pitch_quantizer_core_test NOT OK");
    $finish;
  end

endmodule
